// ----- rtl/sha1sh_pkg.sv -----
// SHA-1 stream hasher: shared types and constants.
// No dependencies; used by every module of the hasher except sha1sh_fifo.
package sha1sh_pkg;

	localparam int unsigned BLOCK_BYTES = 64;
	localparam int unsigned LEN_POS     = 56;
	localparam int unsigned ROUNDS      = 80;
	localparam int unsigned DIGEST_WORDS = 5;

	localparam logic [60:0] MAX_BYTES = 61'h1FFF_FFFF_FFFF_FFFF;
	localparam logic [7:0]  PAD_BYTE  = 8'h80;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [4:0][31:0] SHA1_IV = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	typedef enum logic [1:0] {
		K_ABSORB = 2'd0,
		K_FINAL  = 2'd1,
		K_ERROR  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
		logic        length_error;
	} result_t;

	typedef struct packed {
		logic start;
		logic init;
	} cmp_ctrl_t;

endpackage

// ----- rtl/sha1sh_fifo.sv -----
// Small synchronous FIFO with flop storage, used for the work queue and the result queue.
// No dependencies.
module sha1sh_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

endmodule

// ----- rtl/sha1sh_front.sv -----
// Front end: takes input words, enforces the length limit and classifies them.
// Depends on sha1sh_pkg.
module sha1sh_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                q_full,
	input  logic                operation,
	input  logic [7:0]          data_byte,
	output logic                enq,
	output sha1sh_pkg::item_t   item
);

	logic [60:0] count_q;
	logic        flag_q;
	logic        accept;

	assign accept = push && !q_full;
	assign enq    = accept && (operation || (!flag_q && count_q != sha1sh_pkg::MAX_BYTES));

	always_comb begin
		item.data = data_byte;
		if (!operation) begin
			item.kind = sha1sh_pkg::K_ABSORB;
		end else if (flag_q) begin
			item.kind = sha1sh_pkg::K_ERROR;
		end else begin
			item.kind = sha1sh_pkg::K_FINAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			flag_q  <= 1'b0;
		end else if (accept) begin
			if (operation) begin
				count_q <= '0;
				flag_q  <= 1'b0;
			end else if (!flag_q) begin
				if (count_q == sha1sh_pkg::MAX_BYTES) begin
					flag_q <= 1'b1;
				end else begin
					count_q <= count_q + 61'd1;
				end
			end
		end
	end

endmodule

// ----- rtl/sha1sh_compress.sv -----
// SHA-1 compression unit: one round per cycle over a 16-word schedule window, holds chain words.
// Depends on sha1sh_pkg.
module sha1sh_compress (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sha1sh_pkg::cmp_ctrl_t   ctrl,
	input  logic [511:0]            blk,
	output logic                    busy,
	output logic [4:0][31:0]        chain
);

	localparam logic [6:0] LAST = 7'(sha1sh_pkg::ROUNDS);

	logic [4:0][31:0] chain_q;
	logic [31:0]      win_q [16];
	logic [31:0]      a_q, b_q, c_q, d_q, e_q;
	logic [6:0]       rnd_q;
	logic             busy_q;
	logic [31:0]      f;
	logic [31:0]      k;
	logic [31:0]      tmp;
	logic [31:0]      wx;
	logic [31:0]      w_new;
	logic             finish;

	assign busy   = busy_q;
	assign chain  = chain_q;
	assign finish = busy_q && (rnd_q == LAST);

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = sha1sh_pkg::K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = sha1sh_pkg::K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = sha1sh_pkg::K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = sha1sh_pkg::K3;
		end
		tmp   = {a_q[26:0], a_q[31:27]} + f + e_q + k + win_q[0];
		wx    = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
		w_new = {wx[30:0], wx[31]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			rnd_q   <= '0;
			chain_q <= sha1sh_pkg::SHA1_IV;
		end else begin
			if (ctrl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (finish) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 7'd1;
			end
			if (finish) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end else if (ctrl.init && !busy_q) begin
				chain_q <= sha1sh_pkg::SHA1_IV;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			for (int i = 0; i < 16; i++) begin
				win_q[i] <= blk[511 - 32*i -: 32];
			end
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (busy_q && !finish) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= w_new;
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

endmodule

// ----- rtl/sha1sh_back.sv -----
// Back end: packs bytes into the block buffer, runs padding, drives compression and digest or length-error output.
// Depends on sha1sh_pkg; controls sha1sh_compress.
module sha1sh_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	input  sha1sh_pkg::item_t       item,
	output logic                    item_pop,
	output logic                    res_wr,
	output sha1sh_pkg::result_t     res,
	input  logic                    res_full,
	output sha1sh_pkg::cmp_ctrl_t   cmp_ctrl,
	input  logic                    cmp_busy,
	input  logic [4:0][31:0]        chain,
	output logic [511:0]            blk
);

	typedef enum logic [2:0] {
		S_RUN,
		S_P80,
		S_PZERO,
		S_PLEN,
		S_FINISH,
		S_OUT,
		S_ERR
	} state_t;

	localparam logic [6:0] FILL_FULL = 7'(sha1sh_pkg::BLOCK_BYTES);
	localparam logic [6:0] FILL_LEN  = 7'(sha1sh_pkg::LEN_POS);
	localparam logic [2:0] LAST_IDX  = 3'(sha1sh_pkg::DIGEST_WORDS - 1);

	state_t       state_q;
	logic [6:0]   fill_q;
	logic [60:0]  count_q;
	logic [2:0]   lcnt_q;
	logic [2:0]   idx_q;
	logic [511:0] blk_q;
	logic [63:0]  len_q;
	logic         start;
	logic         can_take;
	logic         take;
	logic [7:0]   tbyte;
	logic [6:0]   fill_base;

	assign blk       = blk_q;
	assign start     = (fill_q == FILL_FULL) && !cmp_busy && (state_q != S_ERR);
	assign can_take  = (fill_q != FILL_FULL) || start;
	assign fill_base = start ? 7'd0 : fill_q;

	always_comb begin
		take           = 1'b0;
		tbyte          = '0;
		item_pop       = 1'b0;
		res_wr         = 1'b0;
		res            = '0;
		cmp_ctrl.start = start;
		cmp_ctrl.init  = 1'b0;
		case (state_q)
			S_RUN: begin
				if (item_valid) begin
					if (item.kind == sha1sh_pkg::K_ABSORB) begin
						take     = can_take;
						tbyte    = item.data;
						item_pop = can_take;
					end else begin
						item_pop = 1'b1;
					end
				end
			end
			S_P80: begin
				take  = can_take;
				tbyte = sha1sh_pkg::PAD_BYTE;
			end
			S_PZERO: begin
				take = can_take && (fill_q != FILL_LEN);
			end
			S_PLEN: begin
				take  = can_take;
				tbyte = len_q[63:56];
			end
			S_OUT: begin
				if (!res_full) begin
					res_wr          = 1'b1;
					res.digest_word = chain[idx_q];
					res.word_index  = idx_q;
					res.last_word   = (idx_q == LAST_IDX);
					cmp_ctrl.init   = (idx_q == LAST_IDX);
				end
			end
			S_ERR: begin
				if (!res_full && !cmp_busy) begin
					res_wr           = 1'b1;
					res.last_word    = 1'b1;
					res.length_error = 1'b1;
					cmp_ctrl.init    = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
			fill_q  <= '0;
			count_q <= '0;
			lcnt_q  <= '0;
			idx_q   <= '0;
		end else begin
			if (state_q == S_ERR && res_wr) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_base + {6'd0, take};
			end
			if (cmp_ctrl.init) begin
				count_q <= '0;
			end else if (state_q == S_RUN && take) begin
				count_q <= count_q + 61'd1;
			end
			case (state_q)
				S_RUN: begin
					if (item_valid && item.kind == sha1sh_pkg::K_FINAL) begin
						state_q <= S_P80;
					end else if (item_valid && item.kind == sha1sh_pkg::K_ERROR) begin
						state_q <= S_ERR;
					end
				end
				S_P80: begin
					if (take) begin
						state_q <= S_PZERO;
					end
				end
				S_PZERO: begin
					if (fill_q == FILL_LEN) begin
						state_q <= S_PLEN;
						lcnt_q  <= '0;
					end
				end
				S_PLEN: begin
					if (take) begin
						lcnt_q <= lcnt_q + 3'd1;
						if (lcnt_q == 3'd7) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					if (fill_q == '0 && !cmp_busy) begin
						state_q <= S_OUT;
						idx_q   <= '0;
					end
				end
				S_OUT: begin
					if (res_wr) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == LAST_IDX) begin
							state_q <= S_RUN;
						end
					end
				end
				S_ERR: begin
					if (res_wr) begin
						state_q <= S_RUN;
					end
				end
				default: begin
					state_q <= S_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			blk_q <= {blk_q[503:0], tbyte};
		end
		if (state_q == S_RUN && item_valid && item.kind == sha1sh_pkg::K_FINAL) begin
			len_q <= {count_q, 3'b000};
		end else if (state_q == S_PLEN && take) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

endmodule

// ----- rtl/sha1_stream_hasher_core.sv -----
// SHA-1 stream hasher top level: front end, work queue, back end, compression unit, result queue.
// Depends on sha1sh_pkg, sha1sh_fifo, sha1sh_front, sha1sh_back, sha1sh_compress.
//
// Message bytes are absorbed one per word (operation 0); a finalize word (operation 1) pads the
// message, appends the 64-bit bit length and queues five big-endian digest words, index 0 first,
// last_word set on word 4. If more than 2^61-1 bytes were sent, finalize yields one result with
// length_error set instead. Either way the hasher then starts a new message. A byte goes into a
// 512-bit shift buffer while the previous block is compressed at one round per cycle, with a
// chain update and an idle state before the next block can start. A finalize writes the padding
// and length bytes (9 to 72) into the buffer, runs up to two compressions, and queues the five
// digest words. The work queue (IN_DEPTH entries) and result queue (OUT_DEPTH entries) let each
// side stall independently.
module sha1_stream_hasher_core #(
	parameter int unsigned IN_DEPTH  = 4,
	parameter int unsigned OUT_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        operation,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word,
	output logic        length_error
);

	localparam int unsigned ITEM_W = $bits(sha1sh_pkg::item_t);
	localparam int unsigned RES_W  = $bits(sha1sh_pkg::result_t);

	sha1sh_pkg::item_t     fe_item;
	logic                  fe_enq;
	logic [ITEM_W-1:0]     q_rdata;
	logic                  q_empty;
	logic                  q_pop;
	sha1sh_pkg::result_t   be_res;
	logic                  be_wr;
	logic                  r_full;
	logic [RES_W-1:0]      r_rdata;
	sha1sh_pkg::result_t   out_res;
	sha1sh_pkg::cmp_ctrl_t cmp_ctrl;
	logic                  cmp_busy;
	logic [4:0][31:0]      chain;
	logic [511:0]          blk;

	sha1sh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.q_full    (full),
		.operation (operation),
		.data_byte (data_byte),
		.enq       (fe_enq),
		.item      (fe_item)
	);

	sha1sh_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (IN_DEPTH)
	) u_work_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fe_enq),
		.wr_data (fe_item),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	sha1sh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!q_empty),
		.item       (sha1sh_pkg::item_t'(q_rdata)),
		.item_pop   (q_pop),
		.res_wr     (be_wr),
		.res        (be_res),
		.res_full   (r_full),
		.cmp_ctrl   (cmp_ctrl),
		.cmp_busy   (cmp_busy),
		.chain      (chain),
		.blk        (blk)
	);

	sha1sh_compress u_compress (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cmp_ctrl),
		.blk    (blk),
		.busy   (cmp_busy),
		.chain  (chain)
	);

	sha1sh_fifo #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (be_wr),
		.wr_data (be_res),
		.full    (r_full),
		.rd_en   (pop),
		.rd_data (r_rdata),
		.empty   (empty)
	);

	assign out_res      = sha1sh_pkg::result_t'(r_rdata);
	assign digest_word  = out_res.digest_word;
	assign word_index   = out_res.word_index;
	assign last_word    = out_res.last_word;
	assign length_error = out_res.length_error;

endmodule

// ----- verif/sha1_stream_hasher_core_tb.sv -----
// Testbench for sha1_stream_hasher_core: streams messages byte by byte with finalize words
// and checks every digest word against an in-bench SHA-1 predictor.
// Depends on sha1sh_pkg and the hasher RTL.
module sha1_stream_hasher_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINAL  = 1'b1;
	localparam int   STALL_LIMIT = 5000;
	localparam int   TAIL_CYCLES = 400;
	localparam int   RANDOM_WORDS = 380;

	typedef struct packed {
		logic       op;
		logic [7:0] data;
	} hash_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        operation = OP_ABSORB;
	logic [7:0]  data_byte = '0;
	logic        pop = 1'b0;
	logic        full;
	logic        empty;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	logic        length_error;

	hash_word_t          pending_words[$];
	sha1sh_pkg::result_t digest_q[$];
	int                  total_words;
	int                  sent_words = 0;
	int                  errors = 0;
	int                  quiet_cycles = 0;

	// predictor state
	logic [31:0] chain[5];
	logic [7:0]  blk[64];
	int          fill;
	logic [60:0] total_bytes;
	logic        overlength;

	sha1_stream_hasher_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.operation(operation),
		.data_byte(data_byte),
		.empty(empty),
		.pop(pop),
		.digest_word(digest_word),
		.word_index(word_index),
		.last_word(last_word),
		.length_error(length_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void restart_message();
		for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS; i++) chain[i] = sha1sh_pkg::SHA1_IV[i];
		fill = 0;
		total_bytes = '0;
		overlength = 1'b0;
	endfunction

	function automatic void compress_block();
		logic [31:0] w[80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < sha1sh_pkg::ROUNDS; i++) begin
			t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
			w[i] = {t[30:0], t[31]};
		end
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
		for (int i = 0; i < sha1sh_pkg::ROUNDS; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = sha1sh_pkg::K0;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = sha1sh_pkg::K1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = sha1sh_pkg::K2;
			end else begin
				f = b ^ c ^ d;
				k = sha1sh_pkg::K3;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[i];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
	endfunction

	function automatic void predict_digest(logic op, logic [7:0] data);
		logic [63:0]         bits;
		sha1sh_pkg::result_t r;
		if (op == OP_ABSORB) begin
			if (overlength) return;
			if (total_bytes >= sha1sh_pkg::MAX_BYTES) begin
				overlength = 1'b1;
				return;
			end
			total_bytes++;
			blk[fill] = data;
			fill++;
			if (fill == sha1sh_pkg::BLOCK_BYTES) begin
				fill = 0;
				compress_block();
			end
			return;
		end
		if (overlength) begin
			r.digest_word = '0;
			r.word_index = '0;
			r.last_word = 1'b1;
			r.length_error = 1'b1;
			digest_q.push_back(r);
			restart_message();
			return;
		end
		bits = {total_bytes, 3'b000};
		blk[fill] = sha1sh_pkg::PAD_BYTE;
		for (int i = fill + 1; i < sha1sh_pkg::BLOCK_BYTES; i++) blk[i] = '0;
		if (fill >= sha1sh_pkg::LEN_POS) begin
			compress_block();
			for (int i = 0; i < sha1sh_pkg::BLOCK_BYTES; i++) blk[i] = '0;
		end
		for (int i = 0; i < 8; i++) blk[sha1sh_pkg::LEN_POS + i] = bits[63 - 8*i -: 8];
		compress_block();
		for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS; i++) begin
			r.digest_word = chain[i];
			r.word_index = 3'(i);
			r.last_word = (i == sha1sh_pkg::DIGEST_WORDS - 1);
			r.length_error = 1'b0;
			digest_q.push_back(r);
		end
		restart_message();
	endfunction

	function automatic void add_word(logic op, logic [7:0] data);
		hash_word_t h;
		h.op = op;
		h.data = data;
		pending_words.push_back(h);
	endfunction

	function automatic void add_message(int len);
		for (int i = 0; i < len; i++) add_word(OP_ABSORB, 8'($urandom));
		add_word(OP_FINAL, 8'($urandom));
	endfunction

	function automatic void flag_error(string msg);
		errors++;
		if (errors <= 10) $display("%0t: %s", $realtime, msg);
	endfunction

	function automatic int sender_idle_pct();
		if (sent_words < total_words / 3) return 34;
		if (sent_words < 2 * total_words / 3) return 76;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (sent_words < total_words / 3) return 76;
		if (sent_words < 2 * total_words / 3) return 34;
		return 0;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			operation <= OP_ABSORB;
			data_byte <= '0;
		end else begin : drive
			hash_word_t h;
			if (push && !full) begin
				predict_digest(operation, data_byte);
				sent_words++;
			end
			if (push && full) begin
				// hold the word until it is taken
			end else if (pending_words.size() != 0 &&
					$urandom_range(0, 99) >= sender_idle_pct()) begin
				h = pending_words.pop_front();
				push <= 1'b1;
				operation <= h.op;
				data_byte <= h.data;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin : watch
			sha1sh_pkg::result_t e;
			if (pop && !empty) begin
				if (digest_q.size() == 0) begin
					flag_error($sformatf("unexpected word: digest %h index %0d last %b err %b",
						digest_word, word_index, last_word, length_error));
				end else begin
					e = digest_q.pop_front();
					if (digest_word !== e.digest_word || word_index !== e.word_index ||
							last_word !== e.last_word || length_error !== e.length_error)
						flag_error($sformatf({"mismatch: exp digest %h index %0d last %b err %b, ",
							"got digest %h index %0d last %b err %b"},
							e.digest_word, e.word_index, e.last_word, e.length_error,
							digest_word, word_index, last_word, length_error));
				end
			end
			pop <= ($urandom_range(0, 99) >= receiver_idle_pct());
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		restart_message();

		// empty message, "abc", single extreme bytes, two-byte message
		add_word(OP_FINAL, 8'hFF);
		add_word(OP_ABSORB, 8'h61);
		add_word(OP_ABSORB, 8'h62);
		add_word(OP_ABSORB, 8'h63);
		add_word(OP_FINAL, 8'h00);
		add_word(OP_ABSORB, 8'h00);
		add_word(OP_FINAL, 8'h5A);
		add_word(OP_ABSORB, 8'hFF);
		add_word(OP_FINAL, 8'hA5);
		add_word(OP_ABSORB, 8'h80);
		add_word(OP_ABSORB, 8'h7F);
		add_word(OP_FINAL, 8'h00);

		// padding fits, padding spills into a second block, full blocks
		add_message(55);
		add_message(56);
		add_message(63);
		add_message(64);
		while (pending_words.size() < RANDOM_WORDS) begin
			if ($urandom_range(0, 7) == 0)
				add_message($urandom_range(55, 130));
			else
				add_message($urandom_range(0, 12));
		end
		total_words = pending_words.size();

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() != 0 || push || digest_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (digest_q.size() != 0)
			flag_error($sformatf("%0d digest words never arrived", digest_q.size()));

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/sha1sh_pkg.sv
rtl/sha1sh_fifo.sv
rtl/sha1sh_front.sv
rtl/sha1sh_compress.sv
rtl/sha1sh_back.sv
rtl/sha1_stream_hasher_core.sv
verif/sha1_stream_hasher_core_tb.sv
